// File: rtl/core/turtle_vector_generator_unit_assert.svh
// Assertion macros for the turtle vector generator checker.
`ifndef TURTLE_VECTOR_GENERATOR_UNIT_ASSERT_SVH
`define TURTLE_VECTOR_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define TVG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("turtle vector generator: same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define TVG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("turtle vector generator: next-cycle check failed");

`endif

// File: rtl/core/tvg_pkg.sv
// Package for the turtle vector generator: word types, opcodes and sine table.
package tvg_pkg;

   localparam int SINE_BITS_DEFAULT = 16;
   localparam int ROM_DEPTH = 91;
   localparam logic [63:0] PI_Q30 = 64'd3373259422;
   localparam logic [63:0] Q23_ONE = 64'd8388608;

   localparam logic [2:0] OP_PEN_UP    = 3'd0;
   localparam logic [2:0] OP_PEN_DOWN  = 3'd1;
   localparam logic [2:0] OP_FORWARD   = 3'd2;
   localparam logic [2:0] OP_TURN_LEFT = 3'd3;
   localparam logic [2:0] OP_TURN_RIGHT = 3'd4;
   localparam logic [2:0] OP_SET_POS   = 3'd5;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [23:0] distance;
      logic [8:0]         turn_degrees;
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } rsp_type;

   typedef logic [23:0] sine_rom_type [0:ROM_DEPTH-1];

   // sin(deg) magnitude, Taylor series in Q2.30, rounded to sine_bits-1 fraction bits
   function automatic logic [23:0] sine_entry(input logic [6:0] deg, input int sine_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] q;
      longint      sum;
      x   = (64'(deg) * PI_Q30) / 64'd180;
      x2  = (x * x) >> 30;
      t   = x;
      sum = longint'(x);
      t = (t * x2) >> 30; t = t / 64'd6;   sum = sum - longint'(t);
      t = (t * x2) >> 30; t = t / 64'd20;  sum = sum + longint'(t);
      t = (t * x2) >> 30; t = t / 64'd42;  sum = sum - longint'(t);
      t = (t * x2) >> 30; t = t / 64'd72;  sum = sum + longint'(t);
      t = (t * x2) >> 30; t = t / 64'd110; sum = sum - longint'(t);
      t = (t * x2) >> 30; t = t / 64'd156; sum = sum + longint'(t);
      t = (t * x2) >> 30; t = t / 64'd210; sum = sum - longint'(t);
      t = (t * x2) >> 30; t = t / 64'd272; sum = sum + longint'(t);
      t = (t * x2) >> 30; t = t / 64'd342; sum = sum - longint'(t);
      if (sum < 0) begin
         sum = 0;
      end
      q = (64'(sum) + 64'd64) >> 7;
      if (q > Q23_ONE) begin
         q = Q23_ONE;
      end
      if (sine_bits < 24) begin
         q = (q + (64'd1 << (23 - sine_bits))) >> (24 - sine_bits);
      end
      return q[23:0];
   endfunction

   function automatic sine_rom_type build_sine_rom(input int sine_bits);
      sine_rom_type rom;
      for (int d = 0; d < ROM_DEPTH; d++) begin
         rom[d] = sine_entry(7'(d), sine_bits);
      end
      return rom;
   endfunction

endpackage

// File: rtl/core/turtle_vector_generator_unit.sv
// Turtle vector generator: command decode, heading/pen/position state, segment output.
// A forward command with the pen down shows its segment in the cycle after acceptance.
// Throughput: one command per cycle while req_ready is high; trig lookup, two multiplies and adds in one pass.
// req_ready drops only while a segment waits on a stalled rsp channel.
// Reset: position 0,0, heading 0 degrees, pen raised, no segment pending.
module turtle_vector_generator_unit
   import tvg_pkg::*;
#(
   parameter int SINE_BITS = SINE_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   localparam int PROD_W = 24 + SINE_BITS;
   localparam sine_rom_type SINE_ROM = build_sine_rom(SINE_BITS);

   logic [31:0] pos_x_ff, pos_x_in;
   logic [31:0] pos_y_ff, pos_y_in;
   logic [8:0]  heading_ff, heading_in;
   logic        pen_raised_ff, pen_raised_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_word_ff, rsp_word_in;

   logic        accept;
   logic        emit;
   logic [8:0]  turn;
   logic [9:0]  turn_sum;
   logic [9:0]  turn_diff;
   logic [8:0]  cos_idx, sin_idx;
   logic        cos_neg, sin_neg;
   logic [31:0] step_x, step_y;

   function automatic logic [31:0] step_comp(input logic [23:0] step_len,
                                             input logic [23:0] rom_val,
                                             input logic tneg);
      logic              dneg;
      logic [23:0]       mag;
      logic [PROD_W-1:0] prod;
      logic [31:0]       r;
      dneg = step_len[23];
      mag  = dneg ? (24'd0 - step_len) : step_len;
      prod = PROD_W'(mag) * PROD_W'(rom_val[SINE_BITS-1:0]);
      prod = prod + (PROD_W'(1) << (SINE_BITS - 2));
      r    = 32'(prod >> (SINE_BITS - 1));
      if (dneg != tneg) begin
         r = 32'd0 - r;
      end
      return r;
   endfunction

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // quadrant folding onto the quarter-wave table
   always_comb begin
      if (heading_ff <= 9'd90) begin
         cos_idx = 9'd90 - heading_ff;  cos_neg = 1'b0;
         sin_idx = heading_ff;          sin_neg = 1'b0;
      end else if (heading_ff <= 9'd180) begin
         cos_idx = heading_ff - 9'd90;  cos_neg = 1'b1;
         sin_idx = 9'd180 - heading_ff; sin_neg = 1'b0;
      end else if (heading_ff <= 9'd270) begin
         cos_idx = 9'd270 - heading_ff; cos_neg = 1'b1;
         sin_idx = heading_ff - 9'd180; sin_neg = 1'b1;
      end else begin
         cos_idx = heading_ff - 9'd270; cos_neg = 1'b0;
         sin_idx = 9'd360 - heading_ff; sin_neg = 1'b1;
      end
      if (cos_idx > 9'd90) begin
         cos_idx = 9'd90;
      end
      if (sin_idx > 9'd90) begin
         sin_idx = 9'd90;
      end
   end

   assign step_x = step_comp(req_word.distance, SINE_ROM[cos_idx[6:0]], cos_neg);
   assign step_y = step_comp(req_word.distance, SINE_ROM[sin_idx[6:0]], sin_neg);

   assign turn      = (req_word.turn_degrees >= 9'd360) ?
                      (req_word.turn_degrees - 9'd360) : req_word.turn_degrees;
   assign turn_sum  = {1'b0, heading_ff} + {1'b0, turn};
   assign turn_diff = {1'b0, heading_ff} - {1'b0, turn};

   always_comb begin
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      heading_in    = heading_ff;
      pen_raised_in = pen_raised_ff;
      emit          = 1'b0;
      if (accept) begin
         case (req_word.opcode)
            OP_PEN_UP: begin
               pen_raised_in = 1'b1;
            end
            OP_PEN_DOWN: begin
               pen_raised_in = 1'b0;
            end
            OP_FORWARD: begin
               pos_x_in = pos_x_ff + step_x;
               pos_y_in = pos_y_ff + step_y;
               emit     = !pen_raised_ff;
            end
            OP_TURN_LEFT: begin
               heading_in = turn_diff[9] ? 9'(turn_diff + 10'd360) : turn_diff[8:0];
            end
            OP_TURN_RIGHT: begin
               heading_in = (turn_sum >= 10'd360) ? 9'(turn_sum - 10'd360) : turn_sum[8:0];
            end
            OP_SET_POS: begin
               pos_x_in = req_word.new_x;
               pos_y_in = req_word.new_y;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_word_in.start_x = pos_x_ff;
         rsp_word_in.start_y = pos_y_ff;
         rsp_word_in.end_x   = pos_x_in;
         rsp_word_in.end_y   = pos_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         heading_ff    <= '0;
         pen_raised_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         heading_ff    <= heading_in;
         pen_raised_ff <= pen_raised_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// File: rtl/core/tvg_checker.sv
// Port-level assertion checker for the turtle vector generator, with its bind.
`include "turtle_vector_generator_unit_assert.svh"

module tvg_checker
   import tvg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_word,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_word
);

   logic fwd_taken;
   logic rsp_stall;

   assign fwd_taken = req_valid && req_ready && (req_word.opcode == OP_FORWARD);
   assign rsp_stall = rsp_valid && !rsp_ready;

   `TVG_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)
   `TVG_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `TVG_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))
   `TVG_ASSERT_NEXT(a_segment_from_forward, clock, reset, !fwd_taken && !rsp_stall, !rsp_valid)

endmodule

bind turtle_vector_generator_unit tvg_checker u_tvg_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for the turtle vector generator: table-driven, heading-sweep and random commands.
module testbench;
   import tvg_pkg::*;

   localparam int          TRIG_BITS     = SINE_BITS_DEFAULT;
   localparam logic [63:0] PI_Q2_30      = 64'd3373259422;
   localparam logic [2:0]  OP_SPARE_LO   = 3'd6;
   localparam logic [2:0]  OP_SPARE_HI   = 3'd7;
   localparam int          SWEEP_STEPS   = 360;
   localparam int          RANDOM_ITEMS  = 830;
   localparam int          MID_DRAIN_AT  = 400;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          CYCLE_LIMIT   = 400000;

   typedef struct {
      req_type cmd;
      bit      pinned;
      rsp_type seg;
   } drill_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;

   logic [23:0] sine_q [0:90];
   logic [31:0] turtle_x;
   logic [31:0] turtle_y;
   logic [8:0]  turtle_heading;
   bit          pen_up;

   drill_row_type directed_rows[$];
   drill_row_type issued_rows[$];
   rsp_type       segments_due[$];

   int mismatches       = 0;
   int commands_taken   = 0;
   int segments_checked = 0;
   int cycle_count      = 0;
   int burst_left       = 0;
   int ready_mode       = 0;
   int ready_span       = 0;
   int ready_phase      = 0;

   turtle_vector_generator_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // sin(deg) magnitude: Q2.30 Taylor series, rounded to TRIG_BITS-1 fraction bits
   function automatic logic [23:0] sine_q_entry(input int deg);
      logic [63:0] ang;
      logic [63:0] ang2;
      logic [63:0] term;
      logic [63:0] q;
      longint      acc;
      ang  = (64'(deg) * PI_Q2_30) / 64'd180;
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc  = longint'(ang);
      for (int n = 1; n <= 9; n++) begin
         term = (term * ang2) >> 30;
         term = term / 64'(4 * n * n + 2 * n);
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      q = (64'(acc) + 64'd64) >> 7;
      if (q > 64'd8388608) begin
         q = 64'd8388608;
      end
      if (TRIG_BITS < 24) begin
         q = (q + (64'd1 << (23 - TRIG_BITS))) >> (24 - TRIG_BITS);
      end
      return q[23:0];
   endfunction

   // one axis of a step: rounded magnitude product, sign from distance xor trig
   function automatic logic [31:0] axis_step(input logic [23:0] step_len,
                                             input logic [23:0] trig_mag,
                                             input bit trig_neg);
      logic [23:0] mag;
      logic [63:0] prod;
      logic [31:0] r;
      bit          dneg;
      dneg = step_len[23];
      mag  = dneg ? -step_len : step_len;
      prod = (64'(mag) * 64'(trig_mag) + (64'd1 << (TRIG_BITS - 2))) >> (TRIG_BITS - 1);
      r    = prod[31:0];
      if (dneg != trig_neg) begin
         r = -r;
      end
      return r;
   endfunction

   task automatic advance_turtle(input req_type w, output bit drew, output rsp_type seg);
      int          h;
      int          turn;
      int          ci;
      int          si;
      bit          cneg;
      bit          sneg;
      h    = int'(turtle_heading);
      turn = int'(w.turn_degrees) % 360;
      drew = 1'b0;
      seg  = '0;
      case (w.opcode)
         OP_PEN_UP: begin
            pen_up = 1'b1;
         end
         OP_PEN_DOWN: begin
            pen_up = 1'b0;
         end
         OP_FORWARD: begin
            if (h <= 90) begin
               ci = 90 - h;  cneg = 1'b0; si = h;       sneg = 1'b0;
            end else if (h <= 180) begin
               ci = h - 90;  cneg = 1'b1; si = 180 - h; sneg = 1'b0;
            end else if (h <= 270) begin
               ci = 270 - h; cneg = 1'b1; si = h - 180; sneg = 1'b1;
            end else begin
               ci = h - 270; cneg = 1'b0; si = 360 - h; sneg = 1'b1;
            end
            seg.start_x = turtle_x;
            seg.start_y = turtle_y;
            turtle_x    = turtle_x + axis_step(w.distance, sine_q[ci], cneg);
            turtle_y    = turtle_y + axis_step(w.distance, sine_q[si], sneg);
            seg.end_x   = turtle_x;
            seg.end_y   = turtle_y;
            drew        = !pen_up;
         end
         OP_TURN_LEFT: begin
            turtle_heading = 9'((h + 360 - turn) % 360);
         end
         OP_TURN_RIGHT: begin
            turtle_heading = 9'((h + turn) % 360);
         end
         OP_SET_POS: begin
            turtle_x = w.new_x;
            turtle_y = w.new_y;
         end
         default: begin
         end
      endcase
   endtask

   task automatic match_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
         mismatches++;
      end
   endtask

   // accepted commands feed the model; accepted words are checked in order
   always @(posedge clock) begin : scoreboard
      drill_row_type row;
      rsp_type       seg;
      rsp_type       want;
      bit            drew;
      if (!reset) begin
         if (req_valid && req_ready) begin
            row.pinned = 1'b0;
            if (issued_rows.size() != 0) begin
               row = issued_rows.pop_front();
            end
            advance_turtle(req_word, drew, seg);
            if (drew) begin
               segments_due.insert(segments_due.size(), row.pinned ? row.seg : seg);
            end
            commands_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (segments_due.size() == 0) begin
               $error("segment word with nothing outstanding: %0d,%0d -> %0d,%0d",
                      rsp_word.start_x, rsp_word.start_y, rsp_word.end_x, rsp_word.end_y);
               mismatches++;
            end else begin
               want = segments_due.pop_front();
               match_field("start_x", want.start_x, rsp_word.start_x);
               match_field("start_y", want.start_y, rsp_word.start_y);
               match_field("end_x", want.end_x, rsp_word.end_x);
               match_field("end_y", want.end_y, rsp_word.end_y);
               segments_checked++;
            end
         end
      end
   end

   // receiver: back-pressure pattern picks a new random mode each time its random span runs out
   always @(posedge clock) begin
      if (ready_span == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_span = $urandom_range(20, 200);
      end else begin
         ready_span = ready_span - 1;
      end
      ready_phase = ready_phase + 1;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ((ready_phase % 6) < 2);
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic req_type cmd(input logic [2:0] op, input logic [23:0] step_len,
                                   input logic [8:0] turn, input logic [31:0] nx,
                                   input logic [31:0] ny);
      req_type c;
      c.opcode       = op;
      c.distance     = step_len;
      c.turn_degrees = turn;
      c.new_x        = nx;
      c.new_y        = ny;
      return c;
   endfunction

   function automatic rsp_type seg_of(input logic [31:0] sx, input logic [31:0] sy,
                                      input logic [31:0] ex, input logic [31:0] ey);
      rsp_type s;
      s.start_x = sx;
      s.start_y = sy;
      s.end_x   = ex;
      s.end_y   = ey;
      return s;
   endfunction

   task automatic add_row(input req_type c, input bit pinned, input rsp_type s);
      drill_row_type r;
      r.cmd    = c;
      r.pinned = pinned;
      r.seg    = s;
      directed_rows.insert(directed_rows.size(), r);
   endtask

   function automatic req_type random_command();
      req_type c;
      int      pick;
      c.distance     = 24'($urandom);
      c.turn_degrees = 9'($urandom);
      c.new_x        = $urandom;
      c.new_y        = $urandom;
      pick           = $urandom_range(0, 99);
      if (pick < 40) begin
         c.opcode = OP_FORWARD;
      end else if (pick < 52) begin
         c.opcode = OP_TURN_LEFT;
      end else if (pick < 64) begin
         c.opcode = OP_TURN_RIGHT;
      end else if (pick < 76) begin
         c.opcode = OP_PEN_DOWN;
      end else if (pick < 82) begin
         c.opcode = OP_PEN_UP;
      end else if (pick < 96) begin
         c.opcode = OP_SET_POS;
      end else begin
         c.opcode = pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
      end
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: c.distance = 24'h7FFFFF;
               1: c.distance = 24'h800000;
               2: c.distance = 24'h000000;
               default: c.distance = 24'hFFFFFF;
            endcase
         end
         1, 2, 3: c.distance = 24'($urandom_range(0, 32767) - 16384);
         default: begin
         end
      endcase
      if ($urandom_range(0, 4) != 0) begin
         c.turn_degrees = 9'($urandom_range(0, 359));
      end
      return c;
   endfunction

   task automatic issue(input req_type c, input bit pinned, input rsp_type s);
      drill_row_type r;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
      end
      burst_left = burst_left - 1;
      r.cmd    = c;
      r.pinned = pinned;
      r.seg    = s;
      issued_rows.insert(issued_rows.size(), r);
      req_valid <= 1'b1;
      req_word  <= c;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the sender off until every outstanding segment has been taken
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (segments_due.size() != 0);
   endtask

   initial begin : stimulus
      req_type c;
      int      counted;
      for (int d = 0; d <= 90; d++) begin
         sine_q[d] = sine_q_entry(d);
      end
      turtle_x       = '0;
      turtle_y       = '0;
      turtle_heading = '0;
      pen_up         = 1'b1;

      // pen is up out of reset, so the first step draws nothing
      add_row(cmd(OP_FORWARD, 24'h000100, 9'd0, 32'hDEADBEEF, 32'h0), 0, '0);
      add_row(cmd(OP_PEN_DOWN, 24'h0, 9'd0, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_FORWARD, 24'h000100, 9'd0, 32'h0, 32'hFFFFFFFF), 1,
              seg_of(32'd256, 32'd0, 32'd512, 32'd0));
      add_row(cmd(OP_TURN_RIGHT, 24'h0, 9'd90, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_FORWARD, 24'h000100, 9'd0, 32'h0, 32'h0), 1,
              seg_of(32'd512, 32'd0, 32'd512, 32'd256));
      add_row(cmd(OP_TURN_LEFT, 24'h0, 9'd270, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_FORWARD, 24'h000100, 9'd0, 32'h0, 32'h0), 1,
              seg_of(32'd512, 32'd256, 32'd256, 32'd256));
      add_row(cmd(OP_TURN_RIGHT, 24'h0, 9'd450, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_FORWARD, 24'h000100, 9'd0, 32'h0, 32'h0), 1,
              seg_of(32'd256, 32'd256, 32'd256, 32'd0));
      add_row(cmd(OP_TURN_LEFT, 24'h0, 9'd511, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_FORWARD, 24'h7FFFFF, 9'd0, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_FORWARD, 24'h800000, 9'd0, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_TURN_RIGHT, 24'h0, 9'd359, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_SPARE_LO, 24'h5A5A5A, 9'd300, 32'h12345678, 32'h9ABCDEF0), 0, '0);
      add_row(cmd(OP_SPARE_HI, 24'hFFFFFF, 9'h1FF, 32'hFFFFFFFF, 32'hFFFFFFFF), 0, '0);
      add_row(cmd(OP_SET_POS, 24'h0, 9'd0, 32'h7FFFFF00, 32'h80000000), 0, '0);
      add_row(cmd(OP_TURN_LEFT, 24'h0, 9'd118, 32'h0, 32'h0), 0, '0);
      // wraps past the top of x, then back under the bottom
      add_row(cmd(OP_FORWARD, 24'h000100, 9'd0, 32'h0, 32'h0), 1,
              seg_of(32'h7FFFFF00, 32'h80000000, 32'h80000000, 32'h80000000));
      add_row(cmd(OP_FORWARD, 24'h800000, 9'd0, 32'h0, 32'h0), 1,
              seg_of(32'h80000000, 32'h80000000, 32'h7F800000, 32'h80000000));
      add_row(cmd(OP_SET_POS, 24'h0, 9'd0, 32'hFFFFFFFF, 32'h7FFFFFFF), 0, '0);
      add_row(cmd(OP_PEN_UP, 24'h0, 9'd0, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_FORWARD, 24'h7FFFFF, 9'd0, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_PEN_DOWN, 24'h0, 9'd0, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_FORWARD, 24'h000000, 9'd0, 32'h0, 32'h0), 1,
              seg_of(32'h007FFFFE, 32'h7FFFFFFF, 32'h007FFFFE, 32'h7FFFFFFF));
      add_row(cmd(OP_TURN_RIGHT, 24'h0, 9'd45, 32'h0, 32'h0), 0, '0);
      add_row(cmd(OP_FORWARD, 24'h7FFFFF, 9'd0, 32'h0, 32'h0), 0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue(directed_rows[i].cmd, directed_rows[i].pinned, directed_rows[i].seg);
      end
      drain();

      // every heading once, one step at each
      issue(cmd(OP_PEN_DOWN, 24'h0, 9'd0, 32'h0, 32'h0), 0, '0);
      for (int h = 0; h < SWEEP_STEPS; h++) begin
         issue(cmd(OP_TURN_RIGHT, 24'($urandom), 9'd1, $urandom, $urandom), 0, '0);
         issue(cmd(OP_FORWARD, 24'($urandom), 9'($urandom), $urandom, $urandom), 0, '0);
      end

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         c = random_command();
         issue(c, 0, '0);
         if (c.opcode <= OP_SET_POS) begin
            counted++;
            if (counted == MID_DRAIN_AT) begin
               drain();
            end
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d commands (table, full heading sweep, random mix incl. unused opcodes)",
               commands_taken);
      $display("Compared %0d drawn segments under sender gaps and receiver back-pressure",
               segments_checked);
      if (mismatches == 0 && segments_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
